### rtl/mseu_pkg.sv
// Shared types and constants for the MIPS subset execute unit.
// Used by mseu_ctrl, mseu_datapath and mips_subset_execute_unit_core.
`default_nettype none

package mseu_pkg;

    localparam int DATA_W    = 32;
    localparam int NUM_REGS  = 32;
    localparam int REG_AW    = 5;
    localparam int MEM_WORDS = 1024;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam logic [REG_AW-1:0] LINK_REG = 5'd31;
    localparam logic [REG_AW-1:0] LAST_REG = 5'(NUM_REGS - 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_OOB  = 2'd2;

    typedef enum logic [4:0] {
        OP_ADD     = 5'd0,
        OP_ADDI    = 5'd1,
        OP_SUB     = 5'd2,
        OP_MUL     = 5'd3,
        OP_AND     = 5'd4,
        OP_OR      = 5'd5,
        OP_ORI     = 5'd6,
        OP_XOR     = 5'd7,
        OP_SLL     = 5'd8,
        OP_SRL     = 5'd9,
        OP_LI      = 5'd10,
        OP_LW      = 5'd11,
        OP_SW      = 5'd12,
        OP_BEQ     = 5'd13,
        OP_BNE     = 5'd14,
        OP_J       = 5'd15,
        OP_JR      = 5'd16,
        OP_JAL     = 5'd17,
        OP_JALR    = 5'd18,
        OP_DUMP    = 5'd19,
        OP_COMMENT = 5'd20
    } op_t;

    // How the execute step finishes an instruction.
    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_DUMP   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        S_CLEAR    = 3'd0,
        S_IDLE     = 3'd1,
        S_EXEC     = 3'd2,
        S_LOAD     = 3'd3,
        S_DUMP_RD  = 3'd4,
        S_DUMP_OUT = 3'd5
    } state_t;

    typedef struct packed {
        logic clear_write;
        logic load_instr;
        logic commit_exec;
        logic mem_read;
        logic commit_load;
        logic dump_start;
        logic dump_read;
        logic dump_emit;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  out_free;
        logic  clear_done;
        logic  dump_last;
    } sts_t;

endpackage

`default_nettype wire

### rtl/mseu_ctrl.sv
// Sequencer for the execute unit: memory clear, fetch, execute, load and dump.
// Depends on mseu_pkg; drives the command struct of mseu_datapath.
`default_nettype none

module mseu_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  mseu_pkg::sts_t     sts,
    output mseu_pkg::cmd_t     cmd
);

    mseu_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mseu_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mseu_pkg::S_CLEAR: begin
                if (sts.clear_done) state_next = mseu_pkg::S_IDLE;
            end
            mseu_pkg::S_IDLE: begin
                if (in_valid) state_next = mseu_pkg::S_EXEC;
            end
            mseu_pkg::S_EXEC: begin
                unique case (sts.kind)
                    mseu_pkg::KIND_LOAD: state_next = mseu_pkg::S_LOAD;
                    mseu_pkg::KIND_DUMP: state_next = mseu_pkg::S_DUMP_RD;
                    default: begin
                        if (sts.out_free) state_next = mseu_pkg::S_IDLE;
                    end
                endcase
            end
            mseu_pkg::S_LOAD: begin
                if (sts.out_free) state_next = mseu_pkg::S_IDLE;
            end
            mseu_pkg::S_DUMP_RD: begin
                state_next = mseu_pkg::S_DUMP_OUT;
            end
            mseu_pkg::S_DUMP_OUT: begin
                if (sts.out_free) begin
                    state_next = sts.dump_last ? mseu_pkg::S_IDLE : mseu_pkg::S_DUMP_RD;
                end
            end
            default: state_next = mseu_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            mseu_pkg::S_CLEAR: begin
                cmd.clear_write = 1'b1;
            end
            mseu_pkg::S_IDLE: begin
                in_ready       = 1'b1;
                cmd.load_instr = in_valid;
            end
            mseu_pkg::S_EXEC: begin
                unique case (sts.kind)
                    mseu_pkg::KIND_LOAD: cmd.mem_read   = 1'b1;
                    mseu_pkg::KIND_DUMP: cmd.dump_start = 1'b1;
                    default:             cmd.commit_exec = sts.out_free;
                endcase
            end
            mseu_pkg::S_LOAD: begin
                cmd.commit_load = sts.out_free;
            end
            mseu_pkg::S_DUMP_RD: begin
                cmd.dump_read = 1'b1;
            end
            mseu_pkg::S_DUMP_OUT: begin
                cmd.dump_emit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/mseu_datapath.sv
// Register file, data memory, pc, halt flag, ALU and result register.
// Depends on mseu_pkg; sequenced by mseu_ctrl through cmd_t and sts_t.
`default_nettype none

module mseu_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  mseu_pkg::cmd_t                        cmd,
    output mseu_pkg::sts_t                        sts,
    input  wire logic [4:0]                       in_mode,
    input  wire logic [mseu_pkg::REG_AW-1:0]      in_dest_reg,
    input  wire logic [mseu_pkg::REG_AW-1:0]      in_src_a_reg,
    input  wire logic [mseu_pkg::REG_AW-1:0]      in_src_b_reg,
    input  wire logic [mseu_pkg::DATA_W-1:0]      in_immediate,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic [1:0]                            out_status,
    output logic [mseu_pkg::DATA_W-1:0]           out_pc_value,
    output logic                                  out_write_valid,
    output logic [mseu_pkg::REG_AW-1:0]           out_reg_index,
    output logic [mseu_pkg::DATA_W-1:0]           out_reg_value,
    output logic                                  out_last
);

    localparam int DW = mseu_pkg::DATA_W;
    localparam int RW = mseu_pkg::REG_AW;
    localparam int AW = mseu_pkg::MEM_AW;

    // Latched instruction
    logic [4:0]    mode_reg;
    logic [RW-1:0] dest_reg;
    logic [DW-1:0] imm_reg;

    // Register file with registered reads and per-entry valid bits
    logic [DW-1:0]          rf_mem [mseu_pkg::NUM_REGS];
    logic [mseu_pkg::NUM_REGS-1:0] rf_valid_reg;
    logic [DW-1:0]          rd_a_reg, rd_b_reg;
    logic                   rd_a_ok_reg, rd_b_ok_reg;
    logic [RW-1:0]          rd_a_addr;
    logic                   rd_en;
    logic [DW-1:0]          op_a, op_b;

    // Data memory
    logic [DW-1:0] dmem [mseu_pkg::MEM_WORDS];
    logic [DW-1:0] mem_rd_reg;
    logic [AW-1:0] clear_cnt_reg;

    logic [DW-1:0] pc_reg;
    logic          halted_reg;
    logic [RW-1:0] dump_cnt_reg;

    // Output register
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [DW-1:0] out_pc_reg;
    logic          out_wv_reg;
    logic [RW-1:0] out_idx_reg;
    logic [DW-1:0] out_val_reg;
    logic          out_last_reg;

    // Execute results
    logic [DW:0]   addr_sum;
    logic          addr_oob;
    logic [AW-1:0] addr_idx;
    logic [DW-1:0] pc_plus4;
    logic [DW-1:0] imm_x4;
    logic [DW-1:0] product;
    logic          ex_wr;
    logic [RW-1:0] ex_widx;
    logic [DW-1:0] ex_wval;
    logic [DW-1:0] ex_next;
    logic [1:0]    ex_status;
    logic          ex_halt;
    logic          ex_store;
    logic          ex_wr_eff;
    mseu_pkg::kind_t ex_kind;

    logic          rf_we;
    logic [RW-1:0] rf_waddr;
    logic [DW-1:0] rf_wdata;
    logic          ld_wr_eff;
    logic          emit;

    // ---------------- register file ----------------
    assign rd_a_addr = cmd.load_instr ? in_src_a_reg : dump_cnt_reg;
    assign rd_en     = cmd.load_instr | cmd.dump_read;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg    <= rf_mem[rd_a_addr];
            rd_a_ok_reg <= rf_valid_reg[rd_a_addr] && (rd_a_addr != '0);
            rd_b_reg    <= rf_mem[in_src_b_reg];
            rd_b_ok_reg <= rf_valid_reg[in_src_b_reg] && (in_src_b_reg != '0);
        end
        if (rf_we) begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
        end else if (rf_we) begin
            rf_valid_reg[rf_waddr] <= 1'b1;
        end
    end

    assign op_a = rd_a_ok_reg ? rd_a_reg : '0;
    assign op_b = rd_b_ok_reg ? rd_b_reg : '0;

    // ---------------- execute ----------------
    assign addr_sum = {op_a[DW-1], op_a} + {imm_reg[DW-1], imm_reg};
    assign addr_oob = addr_sum[DW] || (addr_sum >= (DW+1)'(mseu_pkg::MEM_WORDS));
    assign addr_idx = addr_sum[AW-1:0];
    assign pc_plus4 = pc_reg + DW'(4);
    assign imm_x4   = {imm_reg[DW-3:0], 2'b00};
    assign product  = DW'(op_a * op_b);

    always_comb begin
        ex_wr     = 1'b0;
        ex_widx   = dest_reg;
        ex_wval   = '0;
        ex_next   = pc_plus4;
        ex_status = mseu_pkg::ST_OK;
        ex_halt   = 1'b0;
        ex_store  = 1'b0;
        ex_kind   = mseu_pkg::KIND_SINGLE;
        if (halted_reg) begin
            ex_status = mseu_pkg::ST_HALT;
            ex_next   = pc_reg;
        end else begin
            unique case (mode_reg)
                mseu_pkg::OP_ADD:  begin ex_wr = 1'b1; ex_wval = op_a + op_b; end
                mseu_pkg::OP_ADDI: begin ex_wr = 1'b1; ex_wval = op_a + imm_reg; end
                mseu_pkg::OP_SUB:  begin ex_wr = 1'b1; ex_wval = op_a - op_b; end
                mseu_pkg::OP_MUL:  begin ex_wr = 1'b1; ex_wval = product; end
                mseu_pkg::OP_AND:  begin ex_wr = 1'b1; ex_wval = op_a & op_b; end
                mseu_pkg::OP_OR:   begin ex_wr = 1'b1; ex_wval = op_a | op_b; end
                mseu_pkg::OP_ORI:  begin ex_wr = 1'b1; ex_wval = op_a | imm_reg; end
                mseu_pkg::OP_XOR:  begin ex_wr = 1'b1; ex_wval = op_a ^ op_b; end
                mseu_pkg::OP_SLL:  begin ex_wr = 1'b1; ex_wval = op_a << imm_reg[4:0]; end
                mseu_pkg::OP_SRL:  begin ex_wr = 1'b1; ex_wval = op_a >> imm_reg[4:0]; end
                mseu_pkg::OP_LI:   begin ex_wr = 1'b1; ex_wval = imm_reg; end
                mseu_pkg::OP_LW: begin
                    if (addr_oob) ex_status = mseu_pkg::ST_OOB;
                    else          ex_kind   = mseu_pkg::KIND_LOAD;
                end
                mseu_pkg::OP_SW: begin
                    if (addr_oob) ex_status = mseu_pkg::ST_OOB;
                    else          ex_store  = 1'b1;
                end
                mseu_pkg::OP_BEQ: begin
                    if (op_a == op_b) ex_next = pc_reg + imm_x4;
                end
                mseu_pkg::OP_BNE: begin
                    if (op_a != op_b) ex_next = pc_reg + imm_x4;
                end
                mseu_pkg::OP_J:  ex_next = imm_x4;
                mseu_pkg::OP_JR: ex_next = op_a;
                mseu_pkg::OP_JAL: begin
                    ex_wr = 1'b1; ex_widx = mseu_pkg::LINK_REG;
                    ex_wval = pc_plus4; ex_next = imm_x4;
                end
                mseu_pkg::OP_JALR: begin
                    ex_wr = 1'b1; ex_widx = mseu_pkg::LINK_REG;
                    ex_wval = pc_plus4; ex_next = op_a;
                end
                mseu_pkg::OP_DUMP:    ex_kind = mseu_pkg::KIND_DUMP;
                mseu_pkg::OP_COMMENT: ex_next = pc_reg;
                default: begin
                    ex_halt   = 1'b1;
                    ex_status = mseu_pkg::ST_HALT;
                    ex_next   = pc_reg;
                end
            endcase
        end
    end

    assign ex_wr_eff = ex_wr && (ex_widx != '0);
    assign ld_wr_eff = dest_reg != '0;

    assign rf_we    = (cmd.commit_exec && ex_wr_eff) || (cmd.commit_load && ld_wr_eff);
    assign rf_waddr = cmd.commit_load ? dest_reg : ex_widx;
    assign rf_wdata = cmd.commit_load ? mem_rd_reg : ex_wval;

    // ---------------- data memory ----------------
    always_ff @(posedge aclk) begin
        if (cmd.clear_write) begin
            dmem[clear_cnt_reg] <= '0;
        end else if (cmd.commit_exec && ex_store) begin
            dmem[addr_idx] <= op_b;
        end
        if (cmd.mem_read) begin
            mem_rd_reg <= dmem[addr_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg <= '0;
        end else if (cmd.clear_write) begin
            clear_cnt_reg <= clear_cnt_reg + AW'(1);
        end
    end

    // ---------------- instruction, pc, halt, dump counter ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load_instr) begin
            mode_reg <= in_mode;
            dest_reg <= in_dest_reg;
            imm_reg  <= in_immediate;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            halted_reg   <= 1'b0;
            dump_cnt_reg <= '0;
        end else begin
            if (cmd.commit_exec) begin
                pc_reg <= ex_next;
                if (ex_halt) halted_reg <= 1'b1;
            end
            if (cmd.commit_load || cmd.dump_start) begin
                pc_reg <= pc_plus4;
            end
            if (cmd.dump_start) begin
                dump_cnt_reg <= '0;
            end else if (cmd.dump_emit) begin
                dump_cnt_reg <= dump_cnt_reg + RW'(1);
            end
        end
    end

    // ---------------- result register ----------------
    assign emit = cmd.commit_exec | cmd.commit_load | cmd.dump_emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit_exec) begin
            out_status_reg <= ex_status;
            out_pc_reg     <= ex_next;
            out_wv_reg     <= ex_wr_eff;
            out_idx_reg    <= ex_wr_eff ? ex_widx : '0;
            out_val_reg    <= ex_wr_eff ? ex_wval : '0;
            out_last_reg   <= 1'b1;
        end else if (cmd.commit_load) begin
            out_status_reg <= mseu_pkg::ST_OK;
            out_pc_reg     <= pc_plus4;
            out_wv_reg     <= ld_wr_eff;
            out_idx_reg    <= ld_wr_eff ? dest_reg : '0;
            out_val_reg    <= ld_wr_eff ? mem_rd_reg : '0;
            out_last_reg   <= 1'b1;
        end else if (cmd.dump_emit) begin
            out_status_reg <= mseu_pkg::ST_OK;
            out_pc_reg     <= pc_reg;
            out_wv_reg     <= 1'b0;
            out_idx_reg    <= dump_cnt_reg;
            out_val_reg    <= op_a;
            out_last_reg   <= dump_cnt_reg == mseu_pkg::LAST_REG;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_pc_value    = out_pc_reg;
    assign out_write_valid = out_wv_reg;
    assign out_reg_index   = out_idx_reg;
    assign out_reg_value   = out_val_reg;
    assign out_last        = out_last_reg;

    // ---------------- status to the sequencer ----------------
    assign sts.kind       = ex_kind;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.clear_done = clear_cnt_reg == AW'(mseu_pkg::MEM_WORDS - 1);
    assign sts.dump_last  = dump_cnt_reg == mseu_pkg::LAST_REG;

endmodule

`default_nettype wire

### rtl/mips_subset_execute_unit_core.sv
// MIPS subset execute unit: sequencer plus datapath behind stream ports.
// Requests are taken in S_IDLE only; ALU, store, branch and jump results commit from S_EXEC, lw
// adds S_LOAD (registered memory read); dump alternates S_DUMP_RD and S_DUMP_OUT, one register each.
// A request is not taken before the previous one is through; a held result stalls the next request.
// Reset: control, pc, halt flag and register file clear at once; the data memory then
// clears word by word, all 1024 of them, with s_tready low.
`default_nettype none

module mips_subset_execute_unit_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // dest_reg[4:0], src_a_reg[9:5], src_b_reg[14:10],
                                        // immediate[46:15], zero pad[47]
    input  wire logic [4:0]  s_tuser,   // mode[4:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // pc_value[31:0], reg_index[36:32], reg_value[68:37],
                                        // zero pad[71:69]
    output logic [2:0]       m_tuser,   // status[1:0], write_valid[2]
    output logic             m_tlast
);

    mseu_pkg::cmd_t cmd;
    mseu_pkg::sts_t sts;

    logic [1:0]  out_status;
    logic [31:0] out_pc_value;
    logic        out_write_valid;
    logic [4:0]  out_reg_index;
    logic [31:0] out_reg_value;

    mseu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mseu_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_mode         (s_tuser),
        .in_dest_reg     (s_tdata[4:0]),
        .in_src_a_reg    (s_tdata[9:5]),
        .in_src_b_reg    (s_tdata[14:10]),
        .in_immediate    (s_tdata[46:15]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_status      (out_status),
        .out_pc_value    (out_pc_value),
        .out_write_valid (out_write_valid),
        .out_reg_index   (out_reg_index),
        .out_reg_value   (out_reg_value),
        .out_last        (m_tlast)
    );

    assign m_tdata = {3'b000, out_reg_value, out_reg_index, out_pc_value};
    assign m_tuser = {out_write_valid, out_status};

endmodule

`default_nettype wire

### dv/mseu_checker.sv
`timescale 1ns / 1ps
// Scoreboard for mips_subset_execute_unit_core: watches both stream channels, predicts
// each instruction's results and compares them field by field. Depends on mseu_pkg.
module mseu_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // dest_reg[4:0], src_a_reg[9:5], src_b_reg[14:10],
                                        // immediate[46:15], zero pad[47]
    input  wire logic [4:0]  s_tuser,   // mode[4:0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata,   // pc_value[31:0], reg_index[36:32], reg_value[68:37],
                                        // zero pad[71:69]
    input  wire logic [2:0]  m_tuser,   // status[1:0], write_valid[2]
    input  wire logic        m_tlast,
    output int               n_fail,
    output int               n_pending,
    output int               n_results
);

    typedef struct packed {
        logic [1:0]                  status;
        logic [mseu_pkg::DATA_W-1:0] pc_value;
        logic                        write_valid;
        logic [mseu_pkg::REG_AW-1:0] reg_index;
        logic [mseu_pkg::DATA_W-1:0] reg_value;
        logic                        last;
    } retire_t;

    logic [mseu_pkg::DATA_W-1:0] gpr  [mseu_pkg::NUM_REGS];
    logic [mseu_pkg::DATA_W-1:0] dmem [mseu_pkg::MEM_WORDS];
    logic [mseu_pkg::DATA_W-1:0] pc;
    logic                        halted;
    retire_t                     retire_q [$];

    function automatic logic [mseu_pkg::DATA_W-1:0] gpr_rd(
        input logic [mseu_pkg::REG_AW-1:0] idx);
        return (idx == '0) ? '0 : gpr[idx];
    endfunction

    // Append one expected result at the tail of the queue.
    function automatic void enqueue(input retire_t r);
        retire_q = {retire_q, r};
    endfunction

    task automatic check_field(input string name, input logic [mseu_pkg::DATA_W-1:0] want,
                               input logic [mseu_pkg::DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    // Update the architectural state for one request and queue the results it retires.
    task automatic execute_instr(input logic [4:0] mode,
                                 input logic [mseu_pkg::REG_AW-1:0] rd,
                                 input logic [mseu_pkg::REG_AW-1:0] ra,
                                 input logic [mseu_pkg::REG_AW-1:0] rb,
                                 input logic [mseu_pkg::DATA_W-1:0] imm);
        logic [mseu_pkg::DATA_W-1:0] va, vb, nxt, wval;
        logic [mseu_pkg::REG_AW-1:0] widx;
        logic                        wr;
        logic [1:0]                  st;
        longint                      addr;
        int                          i;

        va   = gpr_rd(ra);
        vb   = gpr_rd(rb);
        nxt  = pc + 32'd4;
        wr   = 1'b0;
        widx = rd;
        wval = '0;
        st   = mseu_pkg::ST_OK;

        if (halted) begin
            enqueue(retire_t'{mseu_pkg::ST_HALT, pc, 1'b0, 5'd0, 32'd0, 1'b1});
            return;
        end

        case (mode) inside
            mseu_pkg::OP_ADD:  begin wr = 1'b1; wval = va + vb; end
            mseu_pkg::OP_ADDI: begin wr = 1'b1; wval = va + imm; end
            mseu_pkg::OP_SUB:  begin wr = 1'b1; wval = va - vb; end
            mseu_pkg::OP_MUL:  begin wr = 1'b1; wval = va * vb; end
            mseu_pkg::OP_AND:  begin wr = 1'b1; wval = va & vb; end
            mseu_pkg::OP_OR:   begin wr = 1'b1; wval = va | vb; end
            mseu_pkg::OP_ORI:  begin wr = 1'b1; wval = va | imm; end
            mseu_pkg::OP_XOR:  begin wr = 1'b1; wval = va ^ vb; end
            mseu_pkg::OP_SLL:  begin wr = 1'b1; wval = va << imm[4:0]; end
            mseu_pkg::OP_SRL:  begin wr = 1'b1; wval = va >> imm[4:0]; end
            mseu_pkg::OP_LI:   begin wr = 1'b1; wval = imm; end
            mseu_pkg::OP_LW, mseu_pkg::OP_SW: begin
                addr = longint'($signed(va)) + longint'($signed(imm));
                if (addr < 0 || addr >= mseu_pkg::MEM_WORDS) begin
                    st = mseu_pkg::ST_OOB;
                end else if (mode == mseu_pkg::OP_LW) begin
                    wr   = 1'b1;
                    wval = dmem[addr];
                end else begin
                    dmem[addr] = vb;
                end
            end
            mseu_pkg::OP_BEQ:  if (va == vb) nxt = pc + (imm << 2);
            mseu_pkg::OP_BNE:  if (va != vb) nxt = pc + (imm << 2);
            mseu_pkg::OP_J:    nxt = imm << 2;
            mseu_pkg::OP_JR:   nxt = va;
            // link is written after the target was read, so jalr through r31 uses the old value
            mseu_pkg::OP_JAL: begin
                wr = 1'b1; widx = mseu_pkg::LINK_REG; wval = pc + 32'd4; nxt = imm << 2;
            end
            mseu_pkg::OP_JALR: begin
                wr = 1'b1; widx = mseu_pkg::LINK_REG; wval = pc + 32'd4; nxt = va;
            end
            mseu_pkg::OP_DUMP: begin
                pc = nxt;
                for (i = 0; i < mseu_pkg::NUM_REGS; i++) begin
                    enqueue(retire_t'{mseu_pkg::ST_OK, nxt, 1'b0, 5'(i), gpr_rd(5'(i)),
                                      1'(i == mseu_pkg::NUM_REGS - 1)});
                end
                return;
            end
            mseu_pkg::OP_COMMENT: nxt = pc;
            default: begin
                halted = 1'b1;
                enqueue(retire_t'{mseu_pkg::ST_HALT, pc, 1'b0, 5'd0, 32'd0, 1'b1});
                return;
            end
        endcase

        // drop writes to r0
        if (wr && widx == '0) wr = 1'b0;
        if (wr) gpr[widx] = wval;
        pc = nxt;
        if (wr) enqueue(retire_t'{st, nxt, 1'b1, widx, wval, 1'b1});
        else    enqueue(retire_t'{st, nxt, 1'b0, 5'd0, 32'd0, 1'b1});
    endtask

    always @(posedge aclk) begin : monitor
        retire_t got, want;
        int      i;
        if (!aresetn) begin
            for (i = 0; i < mseu_pkg::NUM_REGS; i++) gpr[i] = '0;
            for (i = 0; i < mseu_pkg::MEM_WORDS; i++) dmem[i] = '0;
            pc        = '0;
            halted    = 1'b0;
            n_fail    = 0;
            n_results = 0;
            retire_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = retire_t'{m_tuser[1:0], m_tdata[31:0], m_tuser[2], m_tdata[36:32],
                                m_tdata[68:37], m_tlast};
                n_results++;
                if (retire_q.size() == 0) begin
                    $error("result with no request pending: pc %0h index %0d value %0h",
                           got.pc_value, got.reg_index, got.reg_value);
                    n_fail++;
                end else begin
                    want = retire_q.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("pc_value", want.pc_value, got.pc_value);
                    check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
                    check_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
                    check_field("reg_value", want.reg_value, got.reg_value);
                    check_field("last", 32'(want.last), 32'(got.last));
                end
            end
            if (s_tvalid && s_tready)
                execute_instr(s_tuser, s_tdata[4:0], s_tdata[9:5], s_tdata[14:10],
                              s_tdata[46:15]);
        end
        n_pending = retire_q.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for mips_subset_execute_unit_core: clock, reset, instruction stimulus and
// verdict. Prediction and checking live in mseu_checker; opcodes come from mseu_pkg.
module tb_top;

    localparam int N_RANDOM = 440;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [4:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    logic        quiet  = 1'b0;
    int          n_sent = 0;
    int          n_fail, n_pending, n_results;

    mips_subset_execute_unit_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    mseu_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .n_fail(n_fail), .n_pending(n_pending), .n_results(n_results)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 28);
    end

    // Present one request and hold it until accepted; ready is sampled mid-cycle.
    task automatic send_instr(input logic [4:0] mode, input logic [4:0] rd,
                              input logic [4:0] ra, input logic [4:0] rb,
                              input logic [31:0] imm);
        logic rdy;
        while (!quiet && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, imm, rb, ra, rd};
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        n_sent++;
    endtask

    // Favor the low registers so results feed later instructions.
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 9) < 6) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    endfunction

    task automatic send_random_instr();
        int          pick;
        logic [4:0]  mode, rd, ra, rb;
        logic [31:0] imm;
        pick = $urandom_range(0, 99);
        rd   = pick_reg();
        ra   = pick_reg();
        rb   = pick_reg();
        imm  = $urandom;
        if (pick < 14) begin
            mode = mseu_pkg::OP_LI;
            if ($urandom_range(0, 2) == 0) imm = $urandom_range(0, 1100);
        end else if (pick < 52) begin
            mode = 5'($urandom_range(int'(mseu_pkg::OP_ADD), int'(mseu_pkg::OP_SRL)));
        end else if (pick < 72) begin
            mode = ($urandom_range(0, 1) == 0) ? mseu_pkg::OP_LW : mseu_pkg::OP_SW;
            pick = $urandom_range(0, 99);
            // mostly in-range words off r0 from a small pool at both ends of memory
            if (pick < 70) begin
                ra  = 5'd0;
                imm = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                  : mseu_pkg::MEM_WORDS - 16 +
                                                    $urandom_range(0, 15);
            end else if (pick < 85) begin
                imm = $urandom_range(0, 31);
            end
        end else if (pick < 90) begin
            mode = 5'($urandom_range(int'(mseu_pkg::OP_BEQ), int'(mseu_pkg::OP_JALR)));
            if ($urandom_range(0, 9) < 3) rb = ra;
        end else if (pick < 95) begin
            mode = mseu_pkg::OP_COMMENT;
        end else begin
            mode = mseu_pkg::OP_DUMP;
        end
        send_instr(mode, rd, ra, rb, imm);
    endtask

    initial begin : stimulus
        int k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner values, every operation, special cases
        send_instr(mseu_pkg::OP_LI,   5'd1,  5'd0,  5'd0, 32'h7fff_ffff);
        send_instr(mseu_pkg::OP_LI,   5'd2,  5'd0,  5'd0, 32'h8000_0000);
        send_instr(mseu_pkg::OP_LI,   5'd3,  5'd0,  5'd0, 32'hffff_ffff);
        send_instr(mseu_pkg::OP_ADD,  5'd4,  5'd1,  5'd3, 32'd0);
        send_instr(mseu_pkg::OP_ADDI, 5'd5,  5'd1,  5'd0, 32'd1);
        send_instr(mseu_pkg::OP_SUB,  5'd6,  5'd2,  5'd1, 32'd0);
        send_instr(mseu_pkg::OP_MUL,  5'd7,  5'd1,  5'd1, 32'd0);
        send_instr(mseu_pkg::OP_AND,  5'd8,  5'd3,  5'd1, 32'd0);
        send_instr(mseu_pkg::OP_LI,   5'd0,  5'd0,  5'd0, 32'd5);
        send_instr(mseu_pkg::OP_OR,   5'd9,  5'd0,  5'd2, 32'd0);
        send_instr(mseu_pkg::OP_ORI,  5'd10, 5'd2,  5'd0, 32'h0000_ffff);
        send_instr(mseu_pkg::OP_XOR,  5'd11, 5'd3,  5'd1, 32'd0);
        send_instr(mseu_pkg::OP_SLL,  5'd12, 5'd3,  5'd0, 32'd35);
        send_instr(mseu_pkg::OP_SRL,  5'd13, 5'd2,  5'd0, 32'd31);
        send_instr(mseu_pkg::OP_LI,   5'd15, 5'd0,  5'd0, 32'd1000);
        send_instr(mseu_pkg::OP_SW,   5'd0,  5'd15, 5'd3, 32'd23);
        send_instr(mseu_pkg::OP_LW,   5'd16, 5'd15, 5'd0, 32'd23);
        send_instr(mseu_pkg::OP_LW,   5'd17, 5'd15, 5'd0, 32'd24);
        send_instr(mseu_pkg::OP_SW,   5'd0,  5'd15, 5'd1, -32'sd1001);
        send_instr(mseu_pkg::OP_BEQ,  5'd0,  5'd1,  5'd1, -32'sd3);
        send_instr(mseu_pkg::OP_BNE,  5'd0,  5'd1,  5'd2, 32'h7fff_ffff);
        send_instr(mseu_pkg::OP_BEQ,  5'd0,  5'd1,  5'd2, 32'd8);
        send_instr(mseu_pkg::OP_JAL,  5'd0,  5'd0,  5'd0, 32'h4000_0001);
        send_instr(mseu_pkg::OP_JALR, 5'd31, 5'd31, 5'd0, 32'd0);
        send_instr(mseu_pkg::OP_J,    5'd0,  5'd0,  5'd0, 32'hffff_ffff);
        send_instr(mseu_pkg::OP_JR,   5'd0,  5'd1,  5'd0, 32'd0);
        send_instr(mseu_pkg::OP_COMMENT, 5'd7, 5'd3, 5'd2, 32'h1234_5678);
        send_instr(mseu_pkg::OP_DUMP, 5'd0,  5'd0,  5'd0, 32'd0);

        for (k = 0; k < N_RANDOM; k++) begin
            quiet <= (k >= 180 && k < 280);
            send_random_instr();
        end
        quiet <= 1'b0;

        // an unknown opcode halts the unit for good, so it comes last
        send_instr(5'($urandom_range(21, 31)), pick_reg(), pick_reg(), pick_reg(), $urandom);
        send_instr(mseu_pkg::OP_DUMP, 5'd0, 5'd0, 5'd0, 32'd0);
        send_instr(5'd31, 5'd31, 5'd31, 5'd31, 32'hffff_ffff);
        for (k = 0; k < 6; k++)
            send_instr(5'($urandom), pick_reg(), pick_reg(), pick_reg(), $urandom);
        s_tvalid <= 1'b0;

        do @(negedge aclk); while (n_pending != 0);
        repeat (100) @(posedge aclk);
        @(negedge aclk);
        $display("Executed %0d instructions (directed corners, random mix, halt tail);",
                 n_sent);
        $display("compared %0d results including register dumps.", n_results);
        if (n_fail == 0 && n_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
